// ===== hw/rtl/osec_pkg.sv =====
// Shared types, sizes and codes for the origin-sensitive edge checker.
// No dependencies; imported by every module of the block but osec_ram.
`default_nettype none
package osec_pkg;

  // BUCKETS must be a power of two: the bucket index is the low hash bits.
  localparam int BUCKETS  = 256;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int FILL_W   = $clog2(WAYS + 1);
  localparam int TUPLE_W  = 32 + 3 * 64;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CHECK  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_PASS     = 2'd2,
    ST_FAIL     = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [31:0]           reference_id;
    logic [63:0]           call_target;
    logic [63:0]           origin_word;
    logic [63:0]           origin_context;
    logic [BUCKET_W-1:0]   bucket;
    logic                  origin_missing;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/osec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module osec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osec_front.sv =====
// Front end: accepts request transfers, hashes the tuple to a bucket and
// flags a zero origin on checks. Depends on osec_pkg.
`default_nettype none
module osec_front
  import osec_pkg::*;
(
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [31:0] reference_id,
  input  logic [63:0] call_target,
  input  logic [63:0] origin_word,
  input  logic [63:0] origin_context,
  input  q_status_t   q_stat,
  output logic        push,
  output item_t       item
);

  logic [63:0] hash;

  assign hash      = {32'b0, reference_id} ^ call_target ^ origin_word ^ origin_context;
  assign req_stall = q_stat.full;
  assign push      = req_valid && !q_stat.full;

  always_comb begin
    item.opcode         = opcode_t'(opcode);
    item.reference_id   = reference_id;
    item.call_target    = call_target;
    item.origin_word    = origin_word;
    item.origin_context = origin_context;
    item.bucket         = hash[BUCKET_W-1:0];
    item.origin_missing = (opcode_t'(opcode) == OP_CHECK) && (origin_word == 64'd0);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osec_queue.sv =====
// Short queue between front and back end.
// Depends on osec_pkg.
`default_nettype none
module osec_queue
  import osec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t q_stat
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head             = mem[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osec_back.sv =====
// Back end: reads the bucket, compares or inserts, updates the fill count
// and holds the response register. Depends on osec_pkg and osec_ram.
`default_nettype none
module osec_back
  import osec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       q_item,
  input  q_status_t   q_stat,
  output logic        pop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        origin_missing
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t               state;
  item_t                cur;
  logic [BUCKETS-1:0]   fill_valid;
  logic [FILL_W-1:0]    fill_rd;
  logic [FILL_W-1:0]    fill_eff;
  logic [TUPLE_W-1:0]   cur_tuple;
  logic [TUPLE_W-1:0]   way_rd [WAYS];
  logic [WAYS-1:0]      way_hit;
  logic [WAYS-1:0]      tuple_we;
  logic                 bucket_full;
  logic                 do_insert;
  status_t              status_next;

  assign pop = (state == S_IDLE) && q_stat.not_empty && (!rsp_valid || !rsp_stall);

  assign cur_tuple   = {cur.reference_id, cur.call_target, cur.origin_word,
                        cur.origin_context};
  assign fill_eff    = fill_valid[cur.bucket] ? fill_rd : '0;
  assign bucket_full = (fill_eff >= FILL_W'(WAYS));
  assign do_insert   = (state == S_EVAL) && (cur.opcode == OP_INSERT) && !bucket_full;

  osec_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (cur.bucket),
    .wdata (fill_eff + 1'b1),
    .re    (pop),
    .raddr (q_item.bucket),
    .rdata (fill_rd)
  );

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign tuple_we[w] = do_insert && (fill_eff == FILL_W'(w));
    assign way_hit[w]  = (FILL_W'(w) < fill_eff) && (way_rd[w] == cur_tuple);

    osec_ram #(
      .WIDTH (TUPLE_W),
      .DEPTH (BUCKETS)
    ) u_way_ram (
      .clk   (clk),
      .we    (tuple_we[w]),
      .waddr (cur.bucket),
      .wdata (cur_tuple),
      .re    (pop),
      .raddr (q_item.bucket),
      .rdata (way_rd[w])
    );
  end

  always_comb begin
    if (cur.opcode == OP_INSERT) begin
      status_next = bucket_full ? ST_FULL : ST_INSERTED;
    end else begin
      status_next = (|way_hit) ? ST_PASS : ST_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      fill_valid <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= q_item;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          rsp_valid      <= 1'b1;
          status         <= status_next;
          origin_missing <= cur.origin_missing;
          if (do_insert) begin
            fill_valid[cur.bucket] <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/origin_sensitive_edge_checker.sv =====
// Top level of the origin-sensitive edge checker.
// Depends on osec_pkg, osec_front, osec_queue and osec_back.
//
// Request channel (req_valid / req_stall): opcode 0 inserts the tuple
// (reference_id, call_target, origin_word, origin_context) into its bucket,
// opcode 1 checks it. The bucket is the low bits of the XOR of the four words.
// Response channel (rsp_valid / rsp_stall): one transfer per request, in
// order. status is 0 inserted, 1 bucket full (dropped), 2 check passed,
// 3 check failed; origin_missing marks a check with a zero origin.
// A request is written into the queue, then popped with its bucket read
// into the back end's current item, then evaluated into the response
// register. The back end takes no new item before the last one is
// evaluated: the bucket read is followed by the fill count and way update
// in the back end RAMs. A two-entry queue lets the front keep taking requests
// while the back end works or the response waits. A stalled response holds;
// the back end takes no new item until the response register is free, and the queue then fills and raises req_stall.
// Reset clears the per-bucket fill valid bits at once; no clearing pass.
`default_nettype none
module origin_sensitive_edge_checker
  import osec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [31:0] reference_id,
  input  logic [63:0] call_target,
  input  logic [63:0] origin_word,
  input  logic [63:0] origin_context,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        origin_missing
);

  q_status_t q_stat;
  item_t     push_item;
  item_t     q_head;
  logic      push;
  logic      pop;

  osec_front u_front (
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .opcode         (opcode),
    .reference_id   (reference_id),
    .call_target    (call_target),
    .origin_word    (origin_word),
    .origin_context (origin_context),
    .q_stat         (q_stat),
    .push           (push),
    .item           (push_item)
  );

  osec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  osec_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_item         (q_head),
    .q_stat         (q_stat),
    .pop            (pop),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .origin_missing (origin_missing)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/osec_checker.sv =====
// Port-level assertions for the origin-sensitive edge checker, bound to
// the top level. Depends on osec_pkg.
`default_nettype none
module osec_checker
  import osec_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [1:0] status,
  input logic       origin_missing
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(origin_missing))
    else $error("stalled response changed");

  a_missing_on_check: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && origin_missing |-> status == ST_PASS || status == ST_FAIL)
    else $error("origin_missing on an insert response");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_two_cycle_gap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall |=> !rsp_valid)
    else $error("responses closer than two cycles");

endmodule

bind origin_sensitive_edge_checker osec_checker u_osec_checker (.*);
`default_nettype wire
